// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros for the pointer keypad grid RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CHK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: check failed");
`define ASSERT_ANY(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("%m: check failed");
`else
`define ASSERT_CHK(lbl, clk, rst, prop)
`define ASSERT_ANY(lbl, clk, prop)
`endif
`endif

// File: rtl/ptrgrid_pkg.sv
// ----------------------------------------------------------------------------
// ptrgrid_pkg
// Types, widths and constant helpers for the pointer keypad grid block.
// ----------------------------------------------------------------------------
package ptrgrid_pkg;

  localparam int COORD_W = 14;
  localparam int OUT_W   = 24;
  localparam int KEY_W   = 4;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [OUT_W-1:0]   grid_t;
  typedef logic [KEY_W-1:0]   key_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  localparam coord_t WIDTH_RESET  = 14'd1920;
  localparam coord_t HEIGHT_RESET = 14'd1080;

  // Keypad digit of the top left cell; columns add one, rows down subtract three.
  localparam key_t KEY_TOP_LEFT = 4'd7;

  function automatic int pow3(input int n);
    int p;
    p = 1;
    for (int i = 0; i < n; i++) begin
      p = p * 3;
    end
    return p;
  endfunction

endpackage

// File: rtl/ptrgrid_queue.sv
// ----------------------------------------------------------------------------
// ptrgrid_queue
// Small register-based first-in first-out queue with show-ahead read data.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ptrgrid_queue
  import ptrgrid_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output qstat_t           status
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic [AW:0]      count_next;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  assign rdata        = mem[rd_ptr];
  assign status.full  = (count == (AW+1)'(DEPTH));
  assign status.empty = (count == '0);

  `ASSERT_CHK(a_no_overflow, clk, rst, push |-> !status.full)
  `ASSERT_CHK(a_no_underflow, clk, rst, pop |-> !status.empty)
  `ASSERT_ANY(a_reset_clears, clk, rst |=> (count == '0))

endmodule

// File: rtl/ptrgrid_front.sv
// ----------------------------------------------------------------------------
// ptrgrid_front
// Accepts pointer samples, clamps them to the screen and scales them by the
// grid resolution before handing them to the work queue.
// ----------------------------------------------------------------------------
module ptrgrid_front
  import ptrgrid_pkg::*;
#(
  parameter int LEVELS = 7,
  localparam int QW = $clog2(pow3(LEVELS)),
  localparam int RW = COORD_W + QW
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  coord_t        pointer_x,
  input  coord_t        pointer_y,
  input  coord_t        size_x,
  input  coord_t        size_y,
  output logic          q_push,
  output logic [2*RW-1:0] q_data,
  input  logic          q_full
);

  localparam logic [RW-1:0] TRIP = RW'(pow3(LEVELS));

  coord_t          sat_x;
  coord_t          sat_y;
  logic            fv;
  logic [RW-1:0]   prod_x;
  logic [RW-1:0]   prod_y;
  logic            take;

  assign sat_x = (pointer_x >= size_x) ? size_x - 1'b1 : pointer_x;
  assign sat_y = (pointer_y >= size_y) ? size_y - 1'b1 : pointer_y;

  assign full   = fv && q_full;
  assign take   = push && !full;
  assign q_push = fv && !q_full;
  assign q_data = {prod_y, prod_x};

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (take) begin
      fv <= 1'b1;
    end else if (q_push) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      prod_x <= RW'(sat_x) * TRIP;
      prod_y <= RW'(sat_y) * TRIP;
    end
  end

endmodule

// File: rtl/ptrgrid_back.sv
// ----------------------------------------------------------------------------
// ptrgrid_back
// Divides the scaled coordinates by the screen size one quotient bit per
// stage, then takes one base-3 digit pair per stage and builds the decimal
// keypad number.
// ----------------------------------------------------------------------------
module ptrgrid_back
  import ptrgrid_pkg::*;
#(
  parameter int LEVELS = 7,
  localparam int QW = $clog2(pow3(LEVELS)),
  localparam int RW = COORD_W + QW
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [2*RW-1:0] q_data,
  input  logic            q_empty,
  output logic            q_pop,
  input  coord_t          size_x,
  input  coord_t          size_y,
  output logic            out_push,
  output grid_t           out_data,
  input  logic            out_full
);

  logic          adv;
  logic          dv  [QW+1];
  logic [RW-1:0] drx [QW+1];
  logic [RW-1:0] dry [QW+1];
  logic [QW-1:0] dqx [QW+1];
  logic [QW-1:0] dqy [QW+1];
  logic          gv  [LEVELS];
  logic [QW-1:0] gqx [LEVELS];
  logic [QW-1:0] gqy [LEVELS];
  grid_t         gacc [LEVELS];

  assign adv      = !(gv[LEVELS-1] && out_full);
  assign q_pop    = adv && !q_empty;
  assign out_push = adv && gv[LEVELS-1];
  assign out_data = gacc[LEVELS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (adv) begin
      dv[0]  <= !q_empty;
      drx[0] <= q_data[RW-1:0];
      dry[0] <= q_data[2*RW-1:RW];
      dqx[0] <= '0;
      dqy[0] <= '0;
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_div
    localparam int B = QW - 1 - s;
    logic [RW-1:0] dsx;
    logic [RW-1:0] dsy;
    logic          gex;
    logic          gey;

    assign dsx = RW'(size_x) << B;
    assign dsy = RW'(size_y) << B;
    assign gex = (drx[s] >= dsx);
    assign gey = (dry[s] >= dsy);

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[s+1] <= 1'b0;
      end else if (adv) begin
        dv[s+1]  <= dv[s];
        drx[s+1] <= gex ? drx[s] - dsx : drx[s];
        dry[s+1] <= gey ? dry[s] - dsy : dry[s];
        dqx[s+1] <= dqx[s] | (QW'(gex) << B);
        dqy[s+1] <= dqy[s] | (QW'(gey) << B);
      end
    end
  end

  for (genvar k = 0; k < LEVELS; k++) begin : g_dig
    localparam logic [QW-1:0] U1 = QW'(pow3(LEVELS - 1 - k));
    localparam logic [QW-1:0] U2 = QW'(2 * pow3(LEVELS - 1 - k));
    logic          iv;
    logic [QW-1:0] ix;
    logic [QW-1:0] iy;
    grid_t         iacc;
    logic [1:0]    dx;
    logic [1:0]    dy;
    logic [QW-1:0] rx;
    logic [QW-1:0] ry;
    key_t          key;

    if (k == 0) begin : g_src
      assign iv   = dv[QW];
      assign ix   = dqx[QW];
      assign iy   = dqy[QW];
      assign iacc = '0;
    end else begin : g_src
      assign iv   = gv[k-1];
      assign ix   = gqx[k-1];
      assign iy   = gqy[k-1];
      assign iacc = gacc[k-1];
    end

    always_comb begin
      if (ix >= U2) begin
        dx = 2'd2;
        rx = ix - U2;
      end else if (ix >= U1) begin
        dx = 2'd1;
        rx = ix - U1;
      end else begin
        dx = 2'd0;
        rx = ix;
      end
      if (iy >= U2) begin
        dy = 2'd2;
        ry = iy - U2;
      end else if (iy >= U1) begin
        dy = 2'd1;
        ry = iy - U1;
      end else begin
        dy = 2'd0;
        ry = iy;
      end
    end

    assign key = KEY_TOP_LEFT + KEY_W'(dx) - (KEY_W'(dy) + (KEY_W'(dy) << 1));

    always_ff @(posedge clk) begin
      if (rst) begin
        gv[k] <= 1'b0;
      end else if (adv) begin
        gv[k]   <= iv;
        gqx[k]  <= rx;
        gqy[k]  <= ry;
        gacc[k] <= (iacc << 3) + (iacc << 1) + OUT_W'(key);
      end
    end
  end

endmodule

// File: rtl/pointer_to_nested_keypad_grid.sv
// ----------------------------------------------------------------------------
// pointer_to_nested_keypad_grid
// Maps a pointer sample onto a nested 3x3 keypad grid over the screen and
// returns the keypad digits of every level as one decimal number.
//
//   Channel   Handshake                 Payload
//   input     push / full               pointer_x, pointer_y
//   result    pop / empty               grid_number
//   config    psel, penable, pwrite     paddr, pwdata, prdata
//
// One sample is taken every cycle while results are being drained.
// A sample passes through the front register, the work queue, the
// bit-per-stage divider, the digit stages and the result queue on its way
// to the result ports. Reset is synchronous and clears the control state
// and sets the screen size to its default. When the result queue fills, the
// whole back end holds and the work queue then fills up before full rises.
// ----------------------------------------------------------------------------
module pointer_to_nested_keypad_grid
  import ptrgrid_pkg::*;
#(
  parameter int LEVELS = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  coord_t      pointer_x,
  input  coord_t      pointer_y,
  output logic        empty,
  input  logic        pop,
  output grid_t       grid_number,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int QW = $clog2(pow3(LEVELS));
  localparam int RW = COORD_W + QW;

  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  coord_t          screen_width;
  coord_t          screen_height;
  coord_t          size_x;
  coord_t          size_y;
  logic            mq_push;
  logic            mq_pop;
  logic [2*RW-1:0] mq_wdata;
  logic [2*RW-1:0] mq_rdata;
  qstat_t          mq_status;
  logic            oq_push;
  logic            oq_pop;
  grid_t           oq_wdata;
  qstat_t          oq_status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= WIDTH_RESET;
      screen_height <= HEIGHT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_SCREEN_WIDTH: begin
          screen_width <= pwdata[COORD_W-1:0];
        end
        REG_SCREEN_HEIGHT: begin
          screen_height <= pwdata[COORD_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SCREEN_WIDTH: begin
        prdata = 32'(screen_width);
      end
      REG_SCREEN_HEIGHT: begin
        prdata = 32'(screen_height);
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  assign size_x = (screen_width == '0) ? COORD_W'(1) : screen_width;
  assign size_y = (screen_height == '0) ? COORD_W'(1) : screen_height;

  ptrgrid_front #(
    .LEVELS (LEVELS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .pointer_x (pointer_x),
    .pointer_y (pointer_y),
    .size_x    (size_x),
    .size_y    (size_y),
    .q_push    (mq_push),
    .q_data    (mq_wdata),
    .q_full    (mq_status.full)
  );

  ptrgrid_queue #(
    .WIDTH (2*RW),
    .DEPTH (4)
  ) u_work_q (
    .clk    (clk),
    .rst    (rst),
    .push   (mq_push),
    .wdata  (mq_wdata),
    .pop    (mq_pop),
    .rdata  (mq_rdata),
    .status (mq_status)
  );

  ptrgrid_back #(
    .LEVELS (LEVELS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_data   (mq_rdata),
    .q_empty  (mq_status.empty),
    .q_pop    (mq_pop),
    .size_x   (size_x),
    .size_y   (size_y),
    .out_push (oq_push),
    .out_data (oq_wdata),
    .out_full (oq_status.full)
  );

  assign oq_pop = pop && !oq_status.empty;

  ptrgrid_queue #(
    .WIDTH (OUT_W),
    .DEPTH (2)
  ) u_result_q (
    .clk    (clk),
    .rst    (rst),
    .push   (oq_push),
    .wdata  (oq_wdata),
    .pop    (oq_pop),
    .rdata  (grid_number),
    .status (oq_status)
  );

  assign empty = oq_status.empty;

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// Testbench for pointer_to_nested_keypad_grid
// Drives pointer samples through the push/full side, drains the grid numbers
// through the pop/empty side with random stalls on both sides, and compares
// each grid number with a prediction made from the screen size registers.
// The screen size is changed between phases over the APB-style port.
// ----------------------------------------------------------------------------
module tb
  import ptrgrid_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEVELS          = 7;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 210;
  localparam int SETTLE_CYCLES   = 64;
  localparam int STALL_LIMIT     = 4000;

  localparam logic [2:0] ADDR_WIDTH  = 3'd0;
  localparam logic [2:0] ADDR_HEIGHT = 3'd4;

  class grid_scoreboard;
    coord_t width;
    coord_t height;
    grid_t  expected_q[$];
    int     mismatches;

    function new();
      width      = WIDTH_RESET;
      height     = HEIGHT_RESET;
      mismatches = 0;
    endfunction

    function void set_size(logic [2:0] addr, coord_t value);
      if (addr == ADDR_WIDTH) begin
        width = value;
      end else if (addr == ADDR_HEIGHT) begin
        height = value;
      end
    endfunction

    function longint unsigned scale(coord_t coord, coord_t size);
      longint unsigned span;
      longint unsigned c;
      span = (size == 0) ? 1 : size;
      c = (coord >= span) ? span - 1 : coord;
      return (c * (3 ** (LEVELS + 1))) / span;
    endfunction

    function grid_t keypad_code(coord_t x, coord_t y);
      longint unsigned sx;
      longint unsigned sy;
      longint unsigned unit;
      longint unsigned col;
      longint unsigned row;
      longint unsigned acc;
      sx   = scale(x, width);
      sy   = scale(y, height);
      unit = 3 ** LEVELS;
      acc  = 0;
      for (int lvl = 0; lvl < LEVELS; lvl++) begin
        col  = (sx / unit) % 3;
        row  = (sy / unit) % 3;
        sx   = sx - col * unit;
        sy   = sy - row * unit;
        acc  = acc * 10 + KEY_TOP_LEFT + col - 3 * row;
        unit = unit / 3;
      end
      return acc[OUT_W-1:0];
    endfunction

    function void note(coord_t x, coord_t y);
      expected_q.push_back(keypad_code(x, y));
    endfunction

    function void check(grid_t got);
      grid_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: grid number %0d arrived with none expected", $realtime, got);
        end
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: grid_number expected %0d, actual %0d", $realtime, want, got);
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  coord_t      pointer_x = '0;
  coord_t      pointer_y = '0;
  logic        empty;
  logic        pop = 1'b0;
  grid_t       grid_number;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  grid_scoreboard sb = new();
  bit             calm = 1'b0;
  int             quiet_cycles = 0;

  pointer_to_nested_keypad_grid #(.LEVELS(LEVELS)) DUT (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .pointer_x(pointer_x),
    .pointer_y(pointer_y),
    .empty(empty),
    .pop(pop),
    .grid_number(grid_number),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) begin
        sb.note(pointer_x, pointer_y);
      end
      if (pop && !empty) begin
        sb.check(grid_number);
      end
      if ((push && !full) || (pop && !empty) || (psel && penable && pwrite && pready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send_pointer(coord_t x, coord_t y);
    if (!calm && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    push      <= 1'b1;
    pointer_x <= x;
    pointer_y <= y;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic write_size(logic [2:0] addr, coord_t value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {18'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_size(addr, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic drain();
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic coord_t pick_coord(coord_t size);
    int unsigned sel;
    int          v;
    sel = $urandom_range(0, 9);
    if (size == 0 || sel < 2) begin
      return coord_t'($urandom_range(0, 16383));
    end
    if (sel < 4) begin
      v = int'(size) - 2 + int'($urandom_range(0, 3));
      if (v < 0) v = 0;
      if (v > 16383) v = 16383;
      return coord_t'(v);
    end
    return coord_t'($urandom_range(0, size - 1));
  endfunction

  initial begin
    coord_t w;
    coord_t h;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        1: begin w = 14'd16383; h = 14'd16383; end
        2: begin w = 14'd1;     h = 14'd1;     end
        3: begin w = 14'd0;     h = 14'd0;     end
        4: begin w = 14'd3;     h = 14'd16383; end
        5: begin w = 14'd16383; h = 14'd2;     end
        6: begin
          w = coord_t'($urandom_range(1, 64));
          h = coord_t'($urandom_range(1, 64));
        end
        default: begin
          w = coord_t'($urandom_range(1, 16383));
          h = coord_t'($urandom_range(1, 16383));
        end
      endcase
      if (ph > 0) begin
        write_size(ADDR_WIDTH, w);
        write_size(ADDR_HEIGHT, h);
      end
      if (ph == PHASES - 1) begin
        calm = 1'b1;
      end
      if (ph == 0) begin
        send_pointer(14'd0, 14'd0);
        send_pointer(14'd16383, 14'd16383);
        send_pointer(14'd1919, 14'd1079);
        send_pointer(14'd1920, 14'd1080);
        send_pointer(14'd0, 14'd1079);
        send_pointer(14'd1919, 14'd0);
        send_pointer(14'd1, 14'd1);
        send_pointer(14'h2AAA, 14'h1555);
        send_pointer(14'h1555, 14'h2AAA);
        send_pointer(14'd960, 14'd540);
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            send_pointer(coord_t'(320 + 640 * c), coord_t'(180 + 360 * r));
          end
        end
      end
      repeat (ITEMS_PER_PHASE) begin
        send_pointer(pick_coord(sb.width), pick_coord(sb.height));
      end
      push <= 1'b0;
      drain();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/ptrgrid_pkg.sv
rtl/ptrgrid_queue.sv
rtl/ptrgrid_front.sv
rtl/ptrgrid_back.sv
rtl/pointer_to_nested_keypad_grid.sv
sim/tb.sv
